[sv/anp_pkg.sv]
// Shared types and character constants for the ASCII number parser.
package anp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned DigitW = 4;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [DigitW-1:0] digit_t;

  typedef enum logic [ModeW-1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_START      = 2'd0,
    PH_AFTER_SIGN = 2'd1,
    PH_DIGITS     = 2'd2,
    PH_AFTER_ZERO = 2'd3
  } phase_e;

  localparam char_t ChZero   = 8'h30;
  localparam char_t ChNine   = 8'h39;
  localparam char_t ChUpperA = 8'h41;
  localparam char_t ChUpperF = 8'h46;
  localparam char_t ChLowerA = 8'h61;
  localparam char_t ChLowerF = 8'h66;
  localparam char_t ChLowerX = 8'h78;
  localparam char_t ChMinus  = 8'h2D;
  localparam char_t ChPlus   = 8'h2B;

  // Letters A-F and a-f share their low nibble; 'A' has low nibble 1, so add 9.
  localparam digit_t HexLetterOffset = 4'd9;

endpackage

[sv/anp_if.sv]
// Handshake channel interfaces for characters, results and configuration.
interface anp_char_if;
  logic                 valid;
  logic                 ready;
  anp_pkg::char_t       char_code;
  logic                 last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface anp_value_if;
  logic                 valid;
  logic                 ready;
  anp_pkg::value_t      value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface anp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [anp_pkg::ModeW-1:0]    parse_mode;

  modport source (output valid, output parse_mode, input ready);
  modport sink   (input valid, input parse_mode, output ready);
endinterface

[sv/ascii_number_parser_top.sv]
// ASCII decimal/hex string to 64-bit integer converter, one byte per request.
// Throughput: one character request per cycle, sustained while results are taken.
// The final value goes to the result register, or to the skid if that is full.
// A two-entry output buffer (result register plus skid) lets input continue
// while one result waits; char_i.ready drops only when both entries are full.
// Reset clears the mode to unsigned decimal and the string state to its start.
module ascii_number_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  anp_char_if.sink           char_i,
  anp_value_if.source        value_o,
  anp_cfg_if.sink            cfg_i
);

  logic [anp_pkg::ModeW-1:0] mode_q;
  anp_pkg::mode_e            mode;

  anp_pkg::value_t acc_q, acc_d;
  anp_pkg::value_t nacc_q, nacc_d;
  logic            neg_q, neg_d;
  logic            stopped_q, stopped_d;
  anp_pkg::phase_e phase_q, phase_d;

  anp_pkg::value_t out_q, skid_q, result;
  logic            out_valid_q, skid_valid_q;

  logic            accept, push, pop;
  logic            take;
  logic            is_dec, is_upper, is_lower, digit_ok;
  anp_pkg::digit_t digit;
  anp_pkg::value_t digit_ext;
  anp_pkg::char_t  c;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= anp_pkg::MODE_UDEC;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.parse_mode;
    end
  end

  // Mode code 3 behaves as unsigned decimal.
  always_comb begin
    case (mode_q)
      anp_pkg::MODE_SDEC: mode = anp_pkg::MODE_SDEC;
      anp_pkg::MODE_HEX:  mode = anp_pkg::MODE_HEX;
      default:            mode = anp_pkg::MODE_UDEC;
    endcase
  end

  assign c        = char_i.char_code;
  assign is_dec   = (c >= anp_pkg::ChZero)   && (c <= anp_pkg::ChNine);
  assign is_upper = (c >= anp_pkg::ChUpperA) && (c <= anp_pkg::ChUpperF);
  assign is_lower = (c >= anp_pkg::ChLowerA) && (c <= anp_pkg::ChLowerF);
  assign digit    = is_dec ? c[anp_pkg::DigitW-1:0]
                           : c[anp_pkg::DigitW-1:0] + anp_pkg::HexLetterOffset;
  assign digit_ok = (mode == anp_pkg::MODE_HEX) ? (is_dec || is_upper || is_lower) : is_dec;
  assign digit_ext = {{(anp_pkg::ValueW-anp_pkg::DigitW){1'b0}}, digit};

  // The negated accumulator is carried alongside, so the signed result needs
  // only a select at the end of the string.
  always_comb begin
    acc_d     = acc_q;
    nacc_d    = nacc_q;
    neg_d     = neg_q;
    stopped_d = stopped_q;
    phase_d   = phase_q;
    take      = 1'b0;
    if (!stopped_q) begin
      phase_d = anp_pkg::PH_DIGITS;
      take    = 1'b1;
      if (phase_q == anp_pkg::PH_START && mode == anp_pkg::MODE_UDEC
          && c == anp_pkg::ChPlus) begin
        take = 1'b0;
      end else if (phase_q == anp_pkg::PH_START && mode == anp_pkg::MODE_SDEC
                   && c == anp_pkg::ChMinus) begin
        take    = 1'b0;
        neg_d   = 1'b1;
        phase_d = anp_pkg::PH_AFTER_SIGN;
      end else if (phase_q == anp_pkg::PH_START && mode == anp_pkg::MODE_SDEC
                   && c == anp_pkg::ChPlus) begin
        take    = 1'b0;
        phase_d = anp_pkg::PH_AFTER_SIGN;
      end else if (phase_q == anp_pkg::PH_START && mode == anp_pkg::MODE_HEX
                   && c == anp_pkg::ChZero) begin
        phase_d = anp_pkg::PH_AFTER_ZERO;
      end else if (phase_q == anp_pkg::PH_AFTER_SIGN && c == anp_pkg::ChPlus) begin
        take = 1'b0;
      end else if (phase_q == anp_pkg::PH_AFTER_ZERO && mode == anp_pkg::MODE_HEX
                   && c == anp_pkg::ChLowerX) begin
        take = 1'b0;
      end
    end
    if (take) begin
      if (!digit_ok) begin
        stopped_d = 1'b1;
      end else if (mode == anp_pkg::MODE_HEX) begin
        acc_d  = {acc_q[anp_pkg::ValueW-5:0], digit};
        nacc_d = {nacc_q[anp_pkg::ValueW-5:0], 4'b0000} - digit_ext;
      end else begin
        acc_d  = {acc_q[anp_pkg::ValueW-4:0], 3'b000}
               + {acc_q[anp_pkg::ValueW-2:0], 1'b0} + digit_ext;
        nacc_d = {nacc_q[anp_pkg::ValueW-4:0], 3'b000}
               + {nacc_q[anp_pkg::ValueW-2:0], 1'b0} - digit_ext;
      end
    end
  end

  assign result = neg_d ? nacc_d : acc_d;

  assign accept        = char_i.valid && char_i.ready;
  assign push          = accept && char_i.last;
  assign pop           = out_valid_q && value_o.ready;
  assign char_i.ready  = !skid_valid_q;
  assign value_o.valid = out_valid_q;
  assign value_o.value = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      nacc_q    <= '0;
      neg_q     <= 1'b0;
      stopped_q <= 1'b0;
      phase_q   <= anp_pkg::PH_START;
    end else if (accept) begin
      if (char_i.last) begin
        acc_q     <= '0;
        nacc_q    <= '0;
        neg_q     <= 1'b0;
        stopped_q <= 1'b0;
        phase_q   <= anp_pkg::PH_START;
      end else begin
        acc_q     <= acc_d;
        nacc_q    <= nacc_d;
        neg_q     <= neg_d;
        stopped_q <= stopped_d;
        phase_q   <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= result;
        end
      end else if (push) begin
        out_q <= result;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

endmodule

[sv/anp_checker.sv]
// Port-level checks for the ASCII number parser, bound to its top level.
module anp_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            char_valid_i,
  input logic            char_ready_i,
  input logic            char_last_i,
  input logic            value_valid_i,
  input logic            value_ready_i,
  input anp_pkg::value_t value_i
);

  // The input side stalls only while a result is pending on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !char_ready_i |-> value_valid_i)
    else $error("character request stalled with no result pending");

  // A new result can only come from a request marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(value_valid_i) |-> $past(char_valid_i && char_ready_i && char_last_i))
    else $error("result appeared without a last character");

  // With the output empty, the end of a string shows its result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_i && char_ready_i && char_last_i && !value_valid_i) |=> value_valid_i)
    else $error("result missing after last character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (value_valid_i && !value_ready_i) |=> (value_valid_i && $stable(value_i)))
    else $error("stalled result changed or dropped");

endmodule

bind ascii_number_parser_top anp_checker u_anp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .char_valid_i  (char_i.valid),
  .char_ready_i  (char_i.ready),
  .char_last_i   (char_i.last),
  .value_valid_i (value_o.valid),
  .value_ready_i (value_o.ready),
  .value_i       (value_o.value)
);
